### sv/mmr_pkg.sv
package mmr_pkg;

    localparam int MAX_MSGS = 16;
    localparam int MSG_SIZE = 32;

    localparam int IDX_W  = $clog2(MAX_MSGS);
    localparam int STG_W  = $clog2(MSG_SIZE + 1);
    localparam int ADDR_W = $clog2(MAX_MSGS * MSG_SIZE);
    localparam int LEN_W  = 7;
    localparam int PID_W  = 16;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int MAX_LEN_CAP = 64;

    typedef enum logic [STAT_W-1:0] {
        ST_SENT      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NO_DEST   = 3'd2,
        ST_DELIVERED = 3'd3,
        ST_NO_MATCH  = 3'd4
    } t_status;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [PID_W-1:0] sender;
        logic [LEN_W-1:0] length;
    } t_slot_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_pay_wr;

endpackage

### sv/message_mailbox_ring.sv
// Mailbox ring of MAX_MSGS slots holding up to MAX_MSGS-1 messages of at most MSG_SIZE
// bytes. A send word stores its payload byte if has_byte is set and fewer than MSG_SIZE
// are staged; the word marked tlast commits the message (or reports queue full / no
// destination), and its status word is loaded into the output register from S_RESP.
// A receive word walks the slot table from head toward tail, reading each slot in S_SCAN
// and checking its sender in S_CHECK, then reads the matching message out of the payload
// RAM, one byte per S_FETCH and S_EMIT pass. The block takes no new word until the last
// output word of the current one has been loaded into the output register.
module message_mailbox_ring
    import mmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // dest_found[0], sender_pid[16:1], data_byte[24:17], from_pid[40:25], max_len[47:41]
    input  logic [47:0] i_s_axis_tdata,
    // action[0], has_byte[1]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[2:0], msg_length[9:3], out_byte[17:10], zero[23:18]
    output logic [23:0] o_m_axis_tdata,
    // out_valid[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CHECK = 6'b000100,
        S_FETCH = 6'b001000,
        S_EMIT  = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [STG_W-1:0]  r_staged, n_staged;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [PID_W-1:0]  r_from, n_from;
    logic [LEN_W-1:0]  r_max, n_max;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0] r_base, n_base;
    t_status           r_res_status, n_res_status;
    logic [LEN_W-1:0]  r_res_len, n_res_len;

    logic              r_ot_valid;
    t_status           r_ot_status;
    logic [LEN_W-1:0]  r_ot_len;
    logic [BYTE_W-1:0] r_ot_byte;
    logic              r_ot_bvalid;
    logic              r_ot_last;

    logic              w_out_load;
    t_status           w_out_status;
    logic [LEN_W-1:0]  w_out_len;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_out_bvalid;
    logic              w_out_last;
    logic              w_out_free;
    logic              w_accept;

    logic              w_action, w_dest_found, w_has_byte, w_last_byte;
    logic [PID_W-1:0]  w_sender_pid, w_from_pid;
    logic [BYTE_W-1:0] w_data_byte;
    logic [LEN_W-1:0]  w_max_len;

    t_slot_wr          w_slot_wr;
    logic              w_slot_rd_en;
    logic [PID_W-1:0]  w_slot_sender;
    logic [LEN_W-1:0]  w_slot_length;
    t_pay_wr           w_pay_wr;
    logic              w_pay_rd_en;
    logic [ADDR_W-1:0] w_pay_rd_addr;
    logic [BYTE_W-1:0] w_pay_data;

    logic [STG_W-1:0]  w_staged_inc;
    logic [IDX_W-1:0]  w_tail_next;
    logic [IDX_W-1:0]  w_cur_next;
    logic [LEN_W-1:0]  w_clip;

    assign w_dest_found = i_s_axis_tdata[0];
    assign w_sender_pid = i_s_axis_tdata[16:1];
    assign w_data_byte  = i_s_axis_tdata[24:17];
    assign w_from_pid   = i_s_axis_tdata[40:25];
    assign w_max_len    = i_s_axis_tdata[47:41];
    assign w_action     = i_s_axis_tuser[0];
    assign w_has_byte   = i_s_axis_tuser[1];
    assign w_last_byte  = i_s_axis_tlast;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_out_free      = !r_ot_valid || i_m_axis_tready;

    assign w_tail_next = (r_tail == IDX_W'(MAX_MSGS - 1)) ? '0 : r_tail + 1'b1;
    assign w_cur_next  = (r_cur == IDX_W'(MAX_MSGS - 1)) ? '0 : r_cur + 1'b1;

    mmr_slot_mem u_slot (
        .i_clk    (i_clk),
        .i_wr     (w_slot_wr),
        .i_rd_en  (w_slot_rd_en),
        .i_rd_idx (r_cur),
        .o_sender (w_slot_sender),
        .o_length (w_slot_length)
    );

    mmr_payload_mem u_payload (
        .i_clk     (i_clk),
        .i_wr      (w_pay_wr),
        .i_rd_en   (w_pay_rd_en),
        .i_rd_addr (w_pay_rd_addr),
        .o_data    (w_pay_data)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_staged     = r_staged;
        n_cur        = r_cur;
        n_from       = r_from;
        n_max        = r_max;
        n_len        = r_len;
        n_idx        = r_idx;
        n_base       = r_base;
        n_res_status = r_res_status;
        n_res_len    = r_res_len;
        w_out_load   = 1'b0;
        w_out_status = r_res_status;
        w_out_len    = r_res_len;
        w_out_byte   = '0;
        w_out_bvalid = 1'b0;
        w_out_last   = 1'b1;
        w_slot_wr    = '0;
        w_slot_rd_en = 1'b0;
        w_pay_wr     = '0;
        w_pay_rd_en  = 1'b0;
        w_pay_rd_addr = r_base + ADDR_W'(r_idx);
        w_staged_inc = r_staged;
        w_clip       = w_slot_length;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!w_action) begin
                        if (w_has_byte && (r_staged < STG_W'(MSG_SIZE))) begin
                            w_pay_wr.en   = 1'b1;
                            w_pay_wr.addr = ADDR_W'(r_tail) * ADDR_W'(MSG_SIZE)
                                            + ADDR_W'(r_staged);
                            w_pay_wr.data = w_data_byte;
                            w_staged_inc  = r_staged + 1'b1;
                        end
                        n_staged = w_staged_inc;
                        if (w_last_byte) begin
                            n_staged  = '0;
                            n_res_len = '0;
                            n_state   = S_RESP;
                            if (w_tail_next == r_head) begin
                                n_res_status = ST_FULL;
                            end else if (!w_dest_found) begin
                                n_res_status = ST_NO_DEST;
                            end else begin
                                n_res_status     = ST_SENT;
                                n_res_len        = LEN_W'(w_staged_inc);
                                w_slot_wr.en     = 1'b1;
                                w_slot_wr.idx    = r_tail;
                                w_slot_wr.sender = w_sender_pid;
                                w_slot_wr.length = LEN_W'(w_staged_inc);
                                n_tail           = w_tail_next;
                            end
                        end
                    end else begin
                        n_from  = w_from_pid;
                        n_max   = (w_max_len > LEN_W'(MAX_LEN_CAP)) ?
                                  LEN_W'(MAX_LEN_CAP) : w_max_len;
                        n_cur   = r_head;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_cur == r_tail) begin
                    n_res_status = ST_NO_MATCH;
                    n_res_len    = '0;
                    n_state      = S_RESP;
                end else begin
                    w_slot_rd_en = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_from == '0) || (w_slot_sender == r_from)) begin
                    if (w_clip > LEN_W'(MSG_SIZE)) begin
                        w_clip = LEN_W'(MSG_SIZE);
                    end
                    if (w_clip > r_max) begin
                        w_clip = r_max;
                    end
                    n_head = w_cur_next;
                    n_len  = w_clip;
                    n_idx  = '0;
                    n_base = ADDR_W'(r_cur) * ADDR_W'(MSG_SIZE);
                    if (w_clip == '0) begin
                        n_res_status = ST_DELIVERED;
                        n_res_len    = '0;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_FETCH;
                    end
                end else begin
                    n_cur   = w_cur_next;
                    n_state = S_SCAN;
                end
            end
            S_FETCH: begin
                w_pay_rd_en = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_out_status = ST_DELIVERED;
                    w_out_len    = r_len;
                    w_out_byte   = w_pay_data;
                    w_out_bvalid = 1'b1;
                    w_out_last   = (r_idx + 1'b1 == r_len);
                    n_idx        = r_idx + 1'b1;
                    n_state      = w_out_last ? S_IDLE : S_FETCH;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_staged   <= '0;
            r_ot_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_staged <= n_staged;
            if (w_out_load) begin
                r_ot_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ot_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_from       <= n_from;
        r_max        <= n_max;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_base       <= n_base;
        r_res_status <= n_res_status;
        r_res_len    <= n_res_len;
        if (w_out_load) begin
            r_ot_status <= w_out_status;
            r_ot_len    <= w_out_len;
            r_ot_byte   <= w_out_byte;
            r_ot_bvalid <= w_out_bvalid;
            r_ot_last   <= w_out_last;
        end
    end

    assign o_m_axis_tvalid = r_ot_valid;
    assign o_m_axis_tdata  = {6'b0, r_ot_byte, r_ot_len, r_ot_status};
    assign o_m_axis_tuser  = r_ot_bvalid;
    assign o_m_axis_tlast  = r_ot_last;

endmodule

### sv/mmr_slot_mem.sv
module mmr_slot_mem
    import mmr_pkg::*;
(
    input  logic             i_clk,
    input  t_slot_wr         i_wr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [PID_W-1:0] o_sender,
    output logic [LEN_W-1:0] o_length
);

    logic [PID_W-1:0] r_sender [MAX_MSGS];
    logic [LEN_W-1:0] r_length [MAX_MSGS];
    logic [PID_W-1:0] r_rd_sender;
    logic [LEN_W-1:0] r_rd_length;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_sender[i_wr.idx] <= i_wr.sender;
            r_length[i_wr.idx] <= i_wr.length;
        end
        if (i_rd_en) begin
            r_rd_sender <= r_sender[i_rd_idx];
            r_rd_length <= r_length[i_rd_idx];
        end
    end

    assign o_sender = r_rd_sender;
    assign o_length = r_rd_length;

endmodule

### sv/mmr_payload_mem.sv
module mmr_payload_mem
    import mmr_pkg::*;
(
    input  logic              i_clk,
    input  t_pay_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0] o_data
);

    logic [BYTE_W-1:0] r_mem [MAX_MSGS * MSG_SIZE];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_data = r_rd_data;

endmodule
